/* src/unordered_set_table_core_defines.svh */
// Assertion macros shared by the set table RTL
`ifndef UNORDERED_SET_TABLE_CORE_DEFINES_SVH
`define UNORDERED_SET_TABLE_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define UST_CHECK_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a condition in the cycle after a trigger
`define UST_CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* src/ust_pkg.sv */
package ust_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic signed [31:0] value;
    logic signed [31:0] last;
  } tok_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] data;
  } wr_t;

endpackage

/* src/ust_in_if.sv */
interface ust_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

/* src/ust_out_if.sv */
interface ust_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [6:0] position;
  logic       status;
  logic [6:0] count;

  modport source (output valid, output found, output position, output status,
                  output count, input ready);
  modport sink (input valid, input found, input position, input status,
                input count, output ready);
endinterface

/* src/ust_cell.sv */
module ust_cell #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [CW-1:0]  count,
  input  ust_pkg::tok_t  tok_in,
  input  logic [IW-1:0]  pos_in,
  output ust_pkg::tok_t  tok_out,
  output logic [IW-1:0]  pos_out,
  input  ust_pkg::wr_t   wr,
  input  logic [IW-1:0]  wr_idx
);

  localparam logic [IW-1:0] MY_POS  = IW'(IDX);
  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  logic signed [31:0] entry;
  logic               live;
  logic               match;
  logic               is_last;

  assign live    = (MY_IDX < count) && (IDX < DEPTH);
  assign match   = live && (entry == tok_in.value);
  assign is_last = (MY_NEXT == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.value <= tok_in.value;
    tok_out.hit   <= tok_in.hit | match;
    tok_out.last  <= is_last ? entry : tok_in.last;
    pos_out       <= tok_in.hit ? pos_in : MY_POS;
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_idx == MY_POS) begin
      entry <= wr.data;
    end
  end

endmodule

/* src/unordered_set_table_core.sv */
// Channel  Dir  Fields                              Accepted when
// req      in   operation[1:0], value[31:0] signed  req.valid && req.ready
// rsp      out  found, position[6:0], status,        rsp.valid && rsp.ready
//               count[6:0]
// cfg      in   cfg_data[6:0] (capacity_limit)      cfg_we
//
// Per item, the probe walks the row of DEPTH cells, one cell per cycle; then
// the scan result is latched, and in S_DONE the output register is loaded
// and the entry written back, once the output register is free.
// The next item is taken as soon as the result sits in the output register.
// rst is synchronous: count clears, capacity returns to 64, entries undefined.
// A stalled rsp holds the finished result; the next result waits behind it.
`include "unordered_set_table_core_defines.svh"

module unordered_set_table_core #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  ust_in_if.sink     req,
  ust_out_if.source  rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > 7) ? CW : 7;
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t         state;
  logic [1:0]     op;
  logic [CW-1:0]  cnt;
  logic [6:0]     cap;

  ust_pkg::tok_t  tok [DEPTH+1];
  logic [IW-1:0]  tpos [DEPTH+1];

  ust_pkg::wr_t   pend_wr;
  logic [IW-1:0]  pend_idx;
  logic           pend_found;
  logic [CW-1:0]  pend_pos;
  logic           pend_status;
  logic [CW-1:0]  pend_cnt;

  logic           out_valid;
  logic           out_found;
  logic [CW-1:0]  out_pos;
  logic           out_status;
  logic [CW-1:0]  out_cnt;

  ust_pkg::wr_t   wr;
  logic           accept;
  logic           done;
  logic           take;
  logic [MW-1:0]  cap_m;
  logic [MW-1:0]  cap_eff;
  logic [MW-1:0]  cnt_m;
  logic           full;
  logic           present;

  ust_pkg::wr_t   res_wr;
  logic [IW-1:0]  res_idx;
  logic [CW-1:0]  res_pos;
  logic           res_status;
  logic [CW-1:0]  res_cnt;

  assign accept  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign done    = (state == S_SCAN) && tok[DEPTH].valid;
  assign take    = (state == S_DONE) && (!out_valid || rsp.ready);

  assign cap_m   = MW'(cap);
  assign cap_eff = (cap_m > DEPTH_M) ? DEPTH_M : cap_m;
  assign cnt_m   = MW'(cnt);
  assign full    = (cnt_m >= cap_eff);
  assign present = tok[DEPTH].hit;

  assign tok[0]  = '{valid: accept, hit: 1'b0, value: req.value, last: '0};
  assign tpos[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ust_cell #(.DEPTH(DEPTH), .IDX(i), .IW(IW), .CW(CW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (cnt),
      .tok_in  (tok[i]),
      .pos_in  (tpos[i]),
      .tok_out (tok[i+1]),
      .pos_out (tpos[i+1]),
      .wr      (wr),
      .wr_idx  (pend_idx)
    );
  end

  assign wr = '{en: take && pend_wr.en, data: pend_wr.data};

  always_comb begin
    res_wr     = '{en: 1'b0, data: tok[DEPTH].value};
    res_idx    = cnt[IW-1:0];
    res_pos    = present ? CW'(tpos[DEPTH]) : cnt;
    res_status = 1'b0;
    res_cnt    = cnt;
    case (op)
      ust_pkg::OP_INSERT: begin
        if (full) begin
          res_status = 1'b1;
        end else if (!present) begin
          res_wr.en = 1'b1;
          res_cnt   = cnt + CW'(1);
        end
      end
      ust_pkg::OP_DELETE: begin
        if (present) begin
          res_wr  = '{en: 1'b1, data: tok[DEPTH].last};
          res_idx = tpos[DEPTH];
          res_cnt = cnt - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      cap       <= ust_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= req.operation;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (done) begin
            pend_wr     <= res_wr;
            pend_idx    <= res_idx;
            pend_found  <= present;
            pend_pos    <= res_pos;
            pend_status <= res_status;
            pend_cnt    <= res_cnt;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            out_valid  <= 1'b1;
            out_found  <= pend_found;
            out_pos    <= pend_pos;
            out_status <= pend_status;
            out_cnt    <= pend_cnt;
            cnt        <= pend_cnt;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.found    = out_found;
  assign rsp.position = 7'(out_pos);
  assign rsp.status   = out_status;
  assign rsp.count    = 7'(out_cnt);

  `UST_CHECK_NOW(a_cnt_bound, MW'(cnt) <= DEPTH_M, "entry count above depth")
  `UST_CHECK_NEXT(a_accept_scan, accept, state == S_SCAN, "accepted item did not start scan")
  `UST_CHECK_NOW(a_probe_scan, !tok[DEPTH].valid || state == S_SCAN, "probe left row outside scan")
  `UST_CHECK_NEXT(a_take_out, take, out_valid && state == S_IDLE, "result not loaded on take")

endmodule
